// ===== sv/ilid_pkg.sv =====
package ilid_pkg;

  // Storage sizing
  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Field widths of the request and response
  localparam int OP_W   = 3;
  localparam int POS_W  = 16;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [VALUE_WIDTH-1:0] entry_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [LEN_W-1:0]         length;
  } rsp_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== sv/ilid_cell.sv =====
module ilid_cell (
  input  logic                clk,
  input  ilid_pkg::cell_ctrl_t ctrl,
  input  logic [ilid_pkg::IDX_W-1:0] index,
  input  ilid_pkg::entry_t    prev_value,
  input  ilid_pkg::entry_t    next_value,
  input  ilid_pkg::entry_t    new_value,
  output ilid_pkg::entry_t    value,
  output ilid_pkg::entry_t    read_bits
);

  logic hit;
  logic above;

  assign hit   = (index == ctrl.pos);
  assign above = (index > ctrl.pos);

  // Insert: load at the insert point, take from the lower neighbor above it.
  // Delete: take from the upper neighbor at and above the deleted slot.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (hit) begin
        value <= new_value;
      end else if (above) begin
        value <= prev_value;
      end
    end else if (ctrl.del) begin
      if (hit || above) begin
        value <= next_value;
      end
    end
  end

  // Drive the read bus only from the addressed cell
  assign read_bits = hit ? value : '0;

endmodule

// ===== sv/indexed_list_insert_delete.sv =====
// Ordered list of up to 64 signed values held in a row of cells, one entry
// per cell. A request reads, adds at the front or back, inserts before a
// position or deletes at one. On insert the cell at the position loads the
// new value and every cell past it shifts up; on delete every cell at or
// past it shifts down, all in the same clock; a read selects the addressed
// cell. One request is taken per cycle; the single response register frees
// as soon as its response transfers, so req_ready follows rsp_ready while a
// response is pending. Every request returns exactly one response with read
// value, status and the new length. No clearing pass is needed after reset.
module indexed_list_insert_delete (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ilid_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ilid_pkg::rsp_t  rsp
);

  logic [ilid_pkg::CNT_W-1:0] count;
  logic [ilid_pkg::CNT_W-1:0] count_next;
  ilid_pkg::rsp_t             rsp_next;
  ilid_pkg::cell_ctrl_t       ctrl;
  ilid_pkg::entry_t           new_value;
  ilid_pkg::entry_t           values [ilid_pkg::CAPACITY];
  ilid_pkg::entry_t           reads  [ilid_pkg::CAPACITY];
  ilid_pkg::entry_t           read_word;
  logic                       accept;
  logic                       neg;
  logic [ilid_pkg::POS_W-1:0] pos_u;
  logic [ilid_pkg::POS_W-1:0] count_w;
  logic                       in_list;
  logic                       full;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign neg       = req.position[ilid_pkg::POS_W-1];
  assign pos_u     = req.position;
  assign count_w   = ilid_pkg::POS_W'(count);
  assign in_list   = !neg && (pos_u < count_w);
  assign full      = (count == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY));
  assign new_value = ilid_pkg::VALUE_WIDTH'(req.item_value);

  // Read bus: OR of the cell outputs, only the addressed one can be nonzero
  always_comb begin
    read_word = '0;
    for (int i = 0; i < ilid_pkg::CAPACITY; i++) begin
      read_word = read_word | reads[i];
    end
  end

  // Decode the request into a cell command and a response
  always_comb begin
    ctrl       = '0;
    ctrl.pos   = pos_u[ilid_pkg::IDX_W-1:0];
    count_next = count;
    rsp_next.read_value = '1;
    rsp_next.status     = ilid_pkg::ST_DONE;
    case (req.operation)
      ilid_pkg::OP_READ: begin
        if (in_list) begin
          rsp_next.read_value = ilid_pkg::DATA_W'(read_word);
        end else begin
          rsp_next.status = ilid_pkg::ST_RANGE;
        end
      end
      ilid_pkg::OP_FRONT, ilid_pkg::OP_BACK: begin
        if (full) begin
          rsp_next.status = ilid_pkg::ST_FULL;
        end else begin
          ctrl.ins   = 1'b1;
          ctrl.pos   = (req.operation == ilid_pkg::OP_FRONT) ? '0
                       : count[ilid_pkg::IDX_W-1:0];
          count_next = count + ilid_pkg::CNT_W'(1);
        end
      end
      ilid_pkg::OP_INSERT: begin
        if (neg) begin
          ctrl.pos = '0;
        end
        if (!neg && (pos_u > count_w)) begin
          rsp_next.status = ilid_pkg::ST_RANGE;
        end else if (full) begin
          rsp_next.status = ilid_pkg::ST_FULL;
        end else begin
          ctrl.ins   = 1'b1;
          count_next = count + ilid_pkg::CNT_W'(1);
        end
      end
      ilid_pkg::OP_DELETE: begin
        if (in_list) begin
          ctrl.del   = 1'b1;
          count_next = count - ilid_pkg::CNT_W'(1);
        end else begin
          rsp_next.status = ilid_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    rsp_next.length = ilid_pkg::LEN_W'(count_next);
    if (!accept) begin
      ctrl.ins = 1'b0;
      ctrl.del = 1'b0;
    end
  end

  // Row of cells
  for (genvar g = 0; g < ilid_pkg::CAPACITY; g++) begin : g_cell
    ilid_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .index      (ilid_pkg::IDX_W'(g)),
      .prev_value ((g == 0) ? new_value : values[(g == 0) ? 0 : g - 1]),
      .next_value ((g == ilid_pkg::CAPACITY - 1) ? values[g]
                   : values[(g == ilid_pkg::CAPACITY - 1) ? g : g + 1]),
      .new_value  (new_value),
      .value      (values[g]),
      .read_bits  (reads[g])
    );
  end

  // Length and response handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule
